// ===== design/i2cmbs_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmbs_pkg
// shared types and constants of the i2c master byte sequencer
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

  // byte store depth: slot 0 is the slave address, data bytes follow
  localparam int unsigned BufferDepth = 16;
  localparam int unsigned SlotW       = $clog2(BufferDepth);

  // field widths of the transactions
  localparam int unsigned CmdW   = 2;
  localparam int unsigned IndexW = 4;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned OpW    = 3;
  localparam int unsigned BitCntW = 4;
  localparam int unsigned CountW = 4;
  localparam int unsigned NextSlotW = 5;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  // highest data slot that a write transfer may reach
  localparam logic [CountW-1:0] SlotMax = CountW'(BufferDepth - 1);

  // shifter bit counts and line levels
  localparam logic [BitCntW-1:0] BitsByte = BitCntW'(8);
  localparam logic [BitCntW-1:0] BitsAck  = BitCntW'(1);
  localparam logic [BitCntW-1:0] BitsNone = '0;
  localparam logic [ByteW-1:0]   SdaRelease = 8'hFF;
  localparam logic [ByteW-1:0]   ReadBit    = 8'h01;

  typedef enum logic [CmdW-1:0] {
    CMD_WRITE_BYTE  = 2'd0,
    CMD_START_WRITE = 2'd1,
    CMD_START_READ  = 2'd2,
    CMD_SHIFT_DONE  = 2'd3
  } cmd_e;

  typedef enum logic [OpW-1:0] {
    LOP_NONE  = 3'd0,
    LOP_START = 3'd1,
    LOP_BYTE  = 3'd2,
    LOP_READ  = 3'd3,
    LOP_PRIME = 3'd4,
    LOP_STOP  = 3'd5,
    LOP_DONE  = 3'd6
  } line_op_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_TX      = 3'd1,
    PH_RX_ADDR = 3'd2,
    PH_RX_DATA = 3'd3,
    PH_STOP    = 3'd4
  } phase_e;

  // one result of the sequencer
  typedef struct packed {
    line_op_e            line_op;
    logic [ByteW-1:0]    out_byte;
    logic [BitCntW-1:0]  bit_count;
    logic                busy_res;
    logic                nacked;
    logic [ByteW-1:0]    read_data;
  } result_t;

endpackage

// ===== design/i2c_master_byte_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer_unit
// byte-level i2c master sequencer driving a bit shifter, one result per event
// ----------------------------------------------------------------------------
// an accepted input transaction reaches its result on the master side through
//   the input register, then the result register
// throughput: one transaction per cycle while the master side takes results,
//   set by the single-pass decode between the input register and the result register
// reset: rst_ni (asynchronous, active low) empties both registers, returns the
//   sequencer to idle and clears count, slot pointer, nack flag and read byte;
//   the byte store holds no reset value and must be written before use
module i2c_master_byte_sequencer_unit
  import i2cmbs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  // configuration: byte_count register
  input  logic                 cfg_we_i,
  input  logic [CountW-1:0]    cfg_wdata_i,

  // slave side
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [3:0] index, [11:4] data, [12] ack_bit, [20:13] rx_byte, [23:21] zero
  input  logic [InDataW-1:0]   s_axis_tdata,
  // [1:0] command
  input  logic [CmdW-1:0]      s_axis_tuser,

  // master side
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] out_byte, [11:8] bit_count, [12] busy_res, [13] nacked,
  // [21:14] read_data, [23:22] zero
  output logic [OutDataW-1:0]  m_axis_tdata,
  // [2:0] line_op
  output logic [OpW-1:0]       m_axis_tuser
);

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic                in_vld_q;
  cmd_e                cmd_q;
  logic [IndexW-1:0]   index_q;
  logic [ByteW-1:0]    data_q;
  logic                ack_q;
  logic [ByteW-1:0]    rx_q;

  logic                out_vld_q;
  result_t             res_q, res_d;

  // the decode stage moves whenever it holds a transaction and the result register is free or drained
  logic advance;
  assign advance       = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd_q   <= cmd_e'(s_axis_tuser);
      index_q <= s_axis_tdata[3:0];
      data_q  <= s_axis_tdata[11:4];
      ack_q   <= s_axis_tdata[12];
      rx_q    <= s_axis_tdata[20:13];
    end
  end

  // --------------------------------------------------------------------------
  // sequencer state
  // --------------------------------------------------------------------------
  logic [CountW-1:0]    byte_count_q;
  phase_e               phase_q, phase_d;
  logic [NextSlotW-1:0] next_slot_q, next_slot_d;
  logic [CountW-1:0]    tx_limit_q, tx_limit_d;
  logic                 nack_q, nack_d;
  logic [ByteW-1:0]     last_read_q, last_read_d;

  // byte store: slot 0 address, data bytes after it; no reset
  logic [ByteW-1:0]     store_q [BufferDepth];
  logic                 store_we;
  logic                 set_read_bit;
  logic [ByteW-1:0]     addr_byte;
  logic [ByteW-1:0]     slot_byte;

  assign addr_byte = store_q[0];
  // the pointer never exceeds the clamped count when a slot is read
  assign slot_byte = store_q[next_slot_q[SlotW-1:0]];

  // the user must make a register write only while the sequencer is idle; the block itself does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
    end else if (cfg_we_i) begin
      byte_count_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    phase_d      = phase_q;
    next_slot_d  = next_slot_q;
    tx_limit_d   = tx_limit_q;
    nack_d       = nack_q;
    last_read_d  = last_read_q;
    store_we     = 1'b0;
    set_read_bit = 1'b0;

    case (cmd_q)
      CMD_WRITE_BYTE: begin
        // slots beyond the store are dropped
        store_we = (32'(index_q) < BufferDepth);
      end
      CMD_START_WRITE, CMD_START_READ: begin
        if (phase_q == PH_IDLE) begin
          nack_d      = 1'b0;
          next_slot_d = NextSlotW'(1);
          if (cmd_q == CMD_START_WRITE) begin
            tx_limit_d = (byte_count_q > SlotMax) ? SlotMax : byte_count_q;
            phase_d    = PH_TX;
          end else begin
            set_read_bit = 1'b1;
            phase_d      = PH_RX_ADDR;
          end
        end
      end
      default: begin
        // shifter done event
        case (phase_q)
          PH_TX: begin
            if (ack_q || (next_slot_q > NextSlotW'(tx_limit_q))) begin
              nack_d  = ack_q;
              phase_d = PH_STOP;
            end else begin
              next_slot_d = next_slot_q + NextSlotW'(1);
            end
          end
          PH_RX_ADDR: phase_d = PH_RX_DATA;
          PH_RX_DATA: begin
            last_read_d = rx_q;
            phase_d     = PH_STOP;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // result decode
  // --------------------------------------------------------------------------
  always_comb begin
    res_d.line_op   = LOP_NONE;
    res_d.out_byte  = '0;
    res_d.bit_count = BitsNone;

    case (cmd_q)
      CMD_WRITE_BYTE: ;
      CMD_START_WRITE, CMD_START_READ: begin
        if (phase_q == PH_IDLE) begin
          res_d.line_op   = LOP_START;
          res_d.bit_count = BitsByte;
          // a read sends the address with its read bit forced high
          res_d.out_byte  = (cmd_q == CMD_START_READ) ? (addr_byte | ReadBit) : addr_byte;
        end
      end
      default: begin
        case (phase_q)
          PH_TX: begin
            if (ack_q || (next_slot_q > NextSlotW'(tx_limit_q))) begin
              res_d.line_op   = LOP_PRIME;
              res_d.bit_count = BitsAck;
            end else begin
              res_d.line_op   = LOP_BYTE;
              res_d.out_byte  = slot_byte;
              res_d.bit_count = BitsByte;
            end
          end
          PH_RX_ADDR: begin
            // address acknowledge is not checked on a read
            res_d.line_op   = LOP_READ;
            res_d.bit_count = BitsByte;
          end
          PH_RX_DATA: begin
            res_d.line_op   = LOP_PRIME;
            res_d.bit_count = BitsAck;
          end
          PH_STOP: begin
            res_d.line_op  = LOP_STOP;
            res_d.out_byte = SdaRelease;
          end
          default: ;
        endcase
      end
    endcase

    // status reflects the state after this transaction
    res_d.busy_res  = (phase_d != PH_IDLE);
    res_d.nacked    = nack_d;
    res_d.read_data = last_read_d;
  end

  // --------------------------------------------------------------------------
  // state and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      next_slot_q <= '0;
      tx_limit_q  <= '0;
      nack_q      <= 1'b0;
      last_read_q <= '0;
    end else if (advance) begin
      phase_q     <= phase_d;
      next_slot_q <= next_slot_d;
      tx_limit_q  <= tx_limit_d;
      nack_q      <= nack_d;
      last_read_q <= last_read_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (store_we) begin
        store_q[index_q[SlotW-1:0]] <= data_q;
      end else if (set_read_bit) begin
        // read bit stays set in slot 0
        store_q[0] <= addr_byte | ReadBit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = res_q.line_op;
  assign m_axis_tdata  = {2'b00, res_q.read_data, res_q.nacked, res_q.busy_res,
                          res_q.bit_count, res_q.out_byte};

endmodule
